FILE: rtl/fat16_cluster_table_macros.svh
// Assertion macros shared by the cluster table modules.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef FAT16_CLUSTER_TABLE_MACROS_SVH
`define FAT16_CLUSTER_TABLE_MACROS_SVH

// Property must hold on every clock edge outside reset
`define FCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen on a clock edge outside reset
`define FCT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/fct_pkg.sv
// Shared types and constants for the FAT16 cluster table.
// No dependencies; used by every RTL file of the block but fct_ram.
package fct_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 8192;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
    localparam int LINK_W        = 16;
    localparam int CLUSTER_W     = 13;
    localparam int OP_W          = 3;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    // Link codes
    localparam logic [LINK_W-1:0] END_MARK   = 16'hFFFF;
    localparam logic [LINK_W-1:0] MEDIA_MARK = 16'hFFF8;
    localparam logic [LINK_W-1:0] LAST_FLOOR = 16'hFFF8;
    localparam logic [LINK_W-1:0] FREE_LINK  = 16'h0000;

    localparam logic [ADDR_W-1:0]    FIRST_DATA   = ADDR_W'(2);
    localparam logic [ADDR_W-1:0]    LAST_ENTRY   = ADDR_W'(TABLE_ENTRIES - 1);
    localparam logic [CLUSTER_W-1:0] LAST_RESET   = CLUSTER_W'(8152);
    localparam logic [CLUSTER_W-1:0] TOP_CLUSTER  = CLUSTER_W'(TABLE_ENTRIES - 1);

    // Register index (word address bit)
    localparam logic REG_LAST_CLUSTER = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_READ  = 3'd0,
        OP_WRITE = 3'd1,
        OP_ALLOC = 3'd2,
        OP_FREE  = 3'd3,
        OP_CLEAR = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_WAIT,
        ST_WRITE,
        ST_ALLOC_SCAN,
        ST_FREE_CHECK,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_CLUSTER,
        PTR_FIRST,
        PTR_INC,
        PTR_LINK,
        PTR_ZERO
    } ptr_sel_t;

    typedef enum logic [1:0] {
        WD_VALUE,
        WD_END,
        WD_ZERO,
        WD_CLEAR
    } wd_sel_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_DATA,
        RES_PTR
    } res_sel_t;

    // Controller to datapath
    typedef struct packed {
        ptr_sel_t ptr_sel;
        logic     rd_en;
        logic     wr_en;
        wd_sel_t  wd_sel;
        logic     value_load;
        logic     res_load;
        res_sel_t res_sel;
        logic     res_full;
        logic     out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic data_zero;
        logic ptr_at_lim;
        logic lim_small;
        logic cluster_ok;
        logic link_stop;
        logic ptr_last;
        logic slot_busy;
    } sts_t;

endpackage

FILE: rtl/fct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fct_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Storage and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/fct_datapath.sv
// Datapath of the cluster table: link RAM, walk pointer, result and output registers.
// Depends on fct_pkg, fct_ram and fat16_cluster_table_macros.svh.
`include "fat16_cluster_table_macros.svh"

module fct_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fct_pkg::cmd_t                 cmd,
    output fct_pkg::sts_t                 sts,
    input  logic [fct_pkg::ADDR_W-1:0]    lim,
    input  logic [fct_pkg::CLUSTER_W-1:0] cluster,
    input  logic [fct_pkg::LINK_W-1:0]    value,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [fct_pkg::LINK_W-1:0]    result_value,
    output logic                          status
);
    import fct_pkg::*;

    logic [ADDR_W-1:0] ptr_reg;
    logic [ADDR_W-1:0] ptr_next;
    logic [LINK_W-1:0] value_reg;
    logic [LINK_W-1:0] res_value_reg;
    logic              res_status_reg;
    logic [LINK_W-1:0] out_value_reg;
    logic              out_status_reg;
    logic              out_valid_reg;
    logic [LINK_W-1:0] rd_data;
    logic [LINK_W-1:0] wr_data;
    logic [ADDR_W-1:0] cluster_addr;

    assign cluster_addr = ADDR_W'(cluster);

    // Pointer select; the RAM reads at the pointer's next value
    always_comb
    begin
        case (cmd.ptr_sel)
            PTR_HOLD:    ptr_next = ptr_reg;
            PTR_CLUSTER: ptr_next = cluster_addr;
            PTR_FIRST:   ptr_next = FIRST_DATA;
            PTR_INC:     ptr_next = ptr_reg + ADDR_W'(1);
            PTR_LINK:    ptr_next = rd_data[ADDR_W-1:0];
            PTR_ZERO:    ptr_next = '0;
            default:     ptr_next = ptr_reg;
        endcase
    end

    // Write data select
    always_comb
    begin
        case (cmd.wd_sel)
            WD_VALUE: wr_data = value_reg;
            WD_END:   wr_data = END_MARK;
            WD_ZERO:  wr_data = FREE_LINK;
            WD_CLEAR:
            begin
                if (ptr_reg == '0)
                    wr_data = MEDIA_MARK;
                else if (ptr_reg == ADDR_W'(1))
                    wr_data = END_MARK;
                else
                    wr_data = FREE_LINK;
            end
            default:  wr_data = FREE_LINK;
        endcase
    end

    fct_ram #(
        .WIDTH (LINK_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (ptr_reg),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (ptr_next),
        .rd_data (rd_data)
    );

    // Payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (cmd.value_load)
        begin
            value_reg <= value;
        end
        if (cmd.res_load)
        begin
            case (cmd.res_sel)
                RES_ZERO: res_value_reg <= '0;
                RES_DATA: res_value_reg <= rd_data;
                RES_PTR:  res_value_reg <= LINK_W'(ptr_reg);
                default:  res_value_reg <= '0;
            endcase
            res_status_reg <= cmd.res_full;
        end
        if (cmd.out_load)
        begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_value = out_value_reg;
    assign status       = out_status_reg;

    // Status toward the controller
    always_comb
    begin
        sts.data_zero  = (rd_data == FREE_LINK);
        sts.ptr_at_lim = (ptr_reg == lim);
        sts.lim_small  = (lim < FIRST_DATA);
        sts.cluster_ok = (cluster_addr >= FIRST_DATA) && (cluster_addr <= lim);
        // Walk ends on end marks, free links, out-of-range links, or a self link
        sts.link_stop  = (rd_data >= LAST_FLOOR) || (rd_data == FREE_LINK)
                       || (rd_data < LINK_W'(FIRST_DATA)) || (rd_data > LINK_W'(lim))
                       || (rd_data[ADDR_W-1:0] == ptr_reg);
        sts.ptr_last   = (ptr_reg == LAST_ENTRY);
        sts.slot_busy  = out_valid_reg && !result_ready;
    end

    `FCT_NEVER(a_rd_wr_same, cmd.rd_en && cmd.wr_en && (ptr_next == ptr_reg), "read and write hit the same entry")
    `FCT_NEVER(a_out_overrun, cmd.out_load && out_valid_reg && !result_ready, "output register overwritten")
    `FCT_ASSERT(a_mark_range, (cmd.wr_en && cmd.wd_sel == WD_END) |-> ((ptr_reg >= FIRST_DATA) && (ptr_reg <= lim)), "end mark written outside data range")

endmodule

FILE: rtl/fct_ctrl.sv
// Controller state machine of the cluster table: sequences read, write,
// allocate scan, chain free and clear sweep. Depends on fct_pkg and the macro header.
`include "fat16_cluster_table_macros.svh"

module fct_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  logic [fct_pkg::OP_W-1:0] operation,
    output fct_pkg::cmd_t            cmd,
    input  fct_pkg::sts_t            sts
);
    import fct_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = item_valid && (state_reg == ST_IDLE);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    case (op_t'(operation))
                        OP_READ:  state_next = ST_READ_WAIT;
                        OP_WRITE: state_next = ST_WRITE;
                        OP_ALLOC: state_next = sts.lim_small ? ST_DONE : ST_ALLOC_SCAN;
                        OP_FREE:  state_next = sts.cluster_ok ? ST_FREE_CHECK : ST_DONE;
                        OP_CLEAR: state_next = ST_CLEAR;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_READ_WAIT: state_next = ST_DONE;
            ST_WRITE:     state_next = ST_DONE;
            ST_ALLOC_SCAN:
            begin
                if (sts.data_zero || sts.ptr_at_lim)
                    state_next = ST_DONE;
            end
            ST_FREE_CHECK:
            begin
                if (sts.link_stop)
                    state_next = ST_DONE;
            end
            ST_CLEAR:
            begin
                if (sts.ptr_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!sts.slot_busy)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb
    begin
        item_ready     = (state_reg == ST_IDLE);
        cmd            = '0;
        cmd.ptr_sel    = PTR_HOLD;
        cmd.wd_sel     = WD_ZERO;
        cmd.res_sel    = RES_ZERO;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // Default answer: zero, full only for allocate with no range
                    cmd.res_load   = 1'b1;
                    cmd.res_full   = (op_t'(operation) == OP_ALLOC) && sts.lim_small;
                    cmd.value_load = 1'b1;
                    case (op_t'(operation))
                        OP_READ:
                        begin
                            cmd.ptr_sel = PTR_CLUSTER;
                            cmd.rd_en   = 1'b1;
                        end
                        OP_WRITE: cmd.ptr_sel = PTR_CLUSTER;
                        OP_ALLOC:
                        begin
                            cmd.ptr_sel = PTR_FIRST;
                            cmd.rd_en   = !sts.lim_small;
                        end
                        OP_FREE:
                        begin
                            cmd.ptr_sel = PTR_CLUSTER;
                            cmd.rd_en   = sts.cluster_ok;
                        end
                        OP_CLEAR: cmd.ptr_sel = PTR_ZERO;
                        default:  cmd.ptr_sel = PTR_HOLD;
                    endcase
                end
            end
            ST_READ_WAIT:
            begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_DATA;
            end
            ST_WRITE:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wd_sel = WD_VALUE;
            end
            ST_ALLOC_SCAN:
            begin
                if (sts.data_zero)
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.wd_sel   = WD_END;
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_PTR;
                end
                else if (sts.ptr_at_lim)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_full = 1'b1;
                end
                else
                begin
                    cmd.ptr_sel = PTR_INC;
                    cmd.rd_en   = 1'b1;
                end
            end
            ST_FREE_CHECK:
            begin
                cmd.wr_en = 1'b1;
                if (!sts.link_stop)
                begin
                    cmd.ptr_sel = PTR_LINK;
                    cmd.rd_en   = 1'b1;
                end
            end
            ST_CLEAR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wd_sel  = WD_CLEAR;
                cmd.ptr_sel = PTR_INC;
            end
            ST_DONE: cmd.out_load = !sts.slot_busy;
            default: cmd.out_load = 1'b0;
        endcase
    end

    `FCT_ASSERT(a_alloc_hit_done, (state_reg == ST_ALLOC_SCAN && sts.data_zero) |=> (state_reg == ST_DONE), "allocate did not finish on a free entry")
    `FCT_ASSERT(a_clear_walk, (state_reg == ST_CLEAR && !sts.ptr_last) |=> (state_reg == ST_CLEAR), "clear sweep ended early")

endmodule

FILE: rtl/fat16_cluster_table.sv
// Top level of the FAT16 cluster table: APB register, controller and datapath.
// Depends on fct_pkg, fct_ctrl, fct_datapath and fct_ram.
//
// FAT16 cluster link table of 8192 16-bit entries held in one RAM with a
// registered read port. One transaction is worked at a time; its result goes to
// an output register, so the next transaction is taken while a result waits.
// Transactions are paced by the RAM's single read port (one entry a cycle):
// read and write touch one entry, allocate scans entries from cluster 2 until a
// free one or the limit, free chain zeroes the entries of the chain, and clear
// sweeps every entry. The table has no reset value and no clearing pass:
// issue a clear (or write every entry) before reading, allocating or freeing.
// last_cluster sits at address 0x0 and limits allocation and chain walks.
module fat16_cluster_table (
    input  logic                           clk,
    input  logic                           rst_n,
    // Transaction in
    input  logic                           item_valid,
    output logic                           item_ready,
    input  logic [fct_pkg::OP_W-1:0]       operation,
    input  logic [fct_pkg::CLUSTER_W-1:0]  cluster,
    input  logic [fct_pkg::LINK_W-1:0]     value,
    // Transaction out
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic [fct_pkg::LINK_W-1:0]     result_value,
    output logic                           status,
    // APB configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fct_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [fct_pkg::APB_DATA_W-1:0] pwdata,
    output logic [fct_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import fct_pkg::*;

    logic [CLUSTER_W-1:0] last_cluster_reg;
    logic [ADDR_W-1:0]    lim;
    cmd_t                 cmd;
    sts_t                 sts;

    assign pready = 1'b1;

    // Configuration register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_cluster_reg <= LAST_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_LAST_CLUSTER))
        begin
            last_cluster_reg <= pwdata[CLUSTER_W-1:0];
        end
    end

    // Register read
    always_comb
    begin
        if (paddr[2] == REG_LAST_CLUSTER)
            prdata = APB_DATA_W'(last_cluster_reg);
        else
            prdata = '0;
    end

    // Usable limit: smaller of last_cluster and the top table entry
    assign lim = (last_cluster_reg < TOP_CLUSTER) ? ADDR_W'(last_cluster_reg)
                                                  : ADDR_W'(TOP_CLUSTER);

    fct_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .operation  (operation),
        .cmd        (cmd),
        .sts        (sts)
    );

    fct_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .lim          (lim),
        .cluster      (cluster),
        .value        (value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_value (result_value),
        .status       (status)
    );

endmodule
